// ===== hdl/kwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants for the k-way sorted run merge
// Holds the opcodes, register indexes, payload structs and the control
// and status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package kwm_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int VALUE_W = 31;
    localparam int SRC_W   = 3;

    // Operations carried by an input item
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int RLEN_W     = 11;
    localparam int RUSE_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUNS_IN_USE = 1'd1;

    localparam logic [RLEN_W-1:0] RUN_LENGTH_RESET  = 11'd1024;
    localparam logic [RUSE_W-1:0] RUNS_IN_USE_RESET = 4'd8;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] load_value;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [VALUE_W-1:0] merged_value;
        logic [SRC_W-1:0]   source_run;
        logic               all_empty;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage : kwm_pkg
`default_nettype wire

// ===== hdl/kwm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ctrl: merge controller
// Takes input items while idle, runs the head scan for a pop and commits
// the winning head once the output register is free.
// ----------------------------------------------------------------------------
module kwm_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    input  wire logic [kwm_pkg::OP_W-1:0] operation,
    output logic                          item_stall,
    input  wire kwm_pkg::dp_status_t      status,
    output kwm_pkg::ctrl_cmd_t            cmd
);
    import kwm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (operation)
                        OP_LOAD:  cmd.load = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_POP:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        OP_NOP:   ;
                        default:  ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : kwm_ctrl
`default_nettype wire

// ===== hdl/kwm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_datapath: element store, run heads and head compare
// One memory port serves loads and the head scan; the scan reads one head
// per cycle and compares it in the following cycle against the running best.
// ----------------------------------------------------------------------------
module kwm_datapath #(
    parameter int NUM_RUNS  = 8,
    parameter int RUN_DEPTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [kwm_pkg::VALUE_W-1:0]    load_value,
    input  wire kwm_pkg::ctrl_cmd_t             cmd,
    output kwm_pkg::dp_status_t                 status,
    input  wire logic                           cfg_we,
    input  wire logic [kwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output kwm_pkg::out_item_t                  result
);
    import kwm_pkg::*;

    localparam int STORE_DEPTH = NUM_RUNS * RUN_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int HEAD_W      = $clog2(RUN_DEPTH + 1);
    localparam int IDX_W       = $clog2(NUM_RUNS);
    localparam int RUN_W       = $clog2(NUM_RUNS + 1);

    // Configuration registers
    logic [RLEN_W-1:0] run_length_reg;
    logic [RUSE_W-1:0] runs_in_use_reg;

    // Merge state
    logic [HEAD_W-1:0]  heads_reg [NUM_RUNS];
    logic [CNT_W-1:0]   load_count_reg;

    // Scan issue stage
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   base_reg;

    // Compare stage
    logic               cand_valid_reg;
    logic [IDX_W-1:0]   cand_run_reg;
    logic [HEAD_W-1:0]  cand_head_reg;
    logic [VALUE_W-1:0] rdata_reg;

    // Running best
    logic               found_reg;
    logic [VALUE_W-1:0] best_val_reg;
    logic [IDX_W-1:0]   best_run_reg;
    logic [HEAD_W-1:0]  best_head_reg;

    // Output register
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [VALUE_W-1:0] mem [STORE_DEPTH];

    logic [HEAD_W-1:0]  len_used;
    logic [RUN_W-1:0]   runs_used;
    logic [HEAD_W-1:0]  head_cur;
    logic [SUM_W-1:0]   scan_sum;
    logic               head_elig;
    logic               store_full;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic               take;
    logic               fin_found;
    logic [VALUE_W-1:0] fin_val;
    logic [IDX_W-1:0]   fin_run;
    logic [HEAD_W-1:0]  fin_head;

    // Saturated register values
    always_comb
    begin
        priority if (run_length_reg == '0)
        begin
            len_used = HEAD_W'(1);
        end
        else if (32'(run_length_reg) > RUN_DEPTH)
        begin
            len_used = HEAD_W'(RUN_DEPTH);
        end
        else
        begin
            len_used = HEAD_W'(32'(run_length_reg));
        end

        priority if (runs_in_use_reg == '0)
        begin
            runs_used = RUN_W'(1);
        end
        else if (32'(runs_in_use_reg) > NUM_RUNS)
        begin
            runs_used = RUN_W'(NUM_RUNS);
        end
        else
        begin
            runs_used = RUN_W'(32'(runs_in_use_reg));
        end
    end

    // Head address and eligibility for the run being issued
    assign head_cur   = heads_reg[scan_idx_reg];
    assign scan_sum   = SUM_W'(base_reg) + SUM_W'(head_cur);
    assign head_elig  = (head_cur < len_used) && (scan_sum < SUM_W'(load_count_reg));
    assign store_full = (load_count_reg == CNT_W'(STORE_DEPTH));

    assign status.scan_last = ((32'(scan_idx_reg) + 1) == 32'(runs_used));
    assign status.out_free  = !out_valid_reg || !result_stall;

    // Memory port: loads write, the scan reads
    assign mem_we   = cmd.load && !store_full;
    assign mem_re   = cmd.scan_step;
    assign mem_addr = mem_we ? load_count_reg[ADDR_W-1:0] : scan_sum[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= load_value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Compare the fetched head against the best so far; strict less keeps
    // the lowest run on a tie since runs are scanned in ascending order
    assign take      = cand_valid_reg && (!found_reg || (rdata_reg < best_val_reg));
    assign fin_found = found_reg || cand_valid_reg;
    assign fin_val   = take ? rdata_reg     : best_val_reg;
    assign fin_run   = take ? cand_run_reg  : best_run_reg;
    assign fin_head  = take ? cand_head_reg : best_head_reg;

    // Config, counters, heads and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg  <= RUN_LENGTH_RESET;
            runs_in_use_reg <= RUNS_IN_USE_RESET;
            load_count_reg  <= '0;
            for (int i = 0; i < NUM_RUNS; i++)
            begin
                heads_reg[i] <= '0;
            end
            scan_idx_reg    <= '0;
            base_reg        <= '0;
            cand_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RUN_LENGTH:  run_length_reg  <= RLEN_W'(cfg_wdata);
                    REG_RUNS_IN_USE: runs_in_use_reg <= RUSE_W'(cfg_wdata);
                    default:         ;
                endcase
            end

            if (mem_we)
            begin
                load_count_reg <= load_count_reg + CNT_W'(1);
            end

            if (cmd.clear)
            begin
                load_count_reg <= '0;
                for (int i = 0; i < NUM_RUNS; i++)
                begin
                    heads_reg[i] <= '0;
                end
            end

            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                base_reg       <= '0;
                cand_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg   <= scan_idx_reg + IDX_W'(1);
                base_reg       <= base_reg + CNT_W'(len_used);
                cand_valid_reg <= head_elig;
                found_reg      <= fin_found;
            end

            // Output register: a commit loads it, a transfer empties it
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (fin_found)
                begin
                    heads_reg[fin_run] <= fin_head + HEAD_W'(1);
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            cand_run_reg  <= scan_idx_reg;
            cand_head_reg <= head_cur;
            best_val_reg  <= fin_val;
            best_run_reg  <= fin_run;
            best_head_reg <= fin_head;
        end
        if (cmd.commit)
        begin
            if (fin_found)
            begin
                out_data_reg.merged_value <= fin_val;
                out_data_reg.source_run   <= SRC_W'(fin_run);
                out_data_reg.all_empty    <= 1'b0;
            end
            else
            begin
                out_data_reg.merged_value <= '0;
                out_data_reg.source_run   <= '0;
                out_data_reg.all_empty    <= 1'b1;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule : kwm_datapath
`default_nettype wire

// ===== hdl/kway_sorted_run_merge.sv =====
`default_nettype none
// A load or clear is taken while idle; a pop starts a scan that reads each run
//   head in turn from the single port of the element store, then a commit
//   that waits until the output register is free before it returns to idle.
// Throughput: 1 load or clear per cycle while idle; no new item while a pop runs.
// Reset: rst_n clears counters, heads, config and control at once; the
//   element store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// kway_sorted_run_merge: k-way merge of equal-length sorted runs
// Loads fill the store in address order; each pop returns the smallest
// eligible run head and advances it, or flags all_empty if no head is eligible.
// ----------------------------------------------------------------------------
module kway_sorted_run_merge #(
    parameter int NUM_RUNS  = 8,
    parameter int RUN_DEPTH = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire kwm_pkg::in_item_t              item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output kwm_pkg::out_item_t                  result,
    input  wire logic                           cfg_we,
    input  wire logic [kwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import kwm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller
    kwm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (item.operation),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath
    kwm_datapath #(
        .NUM_RUNS  (NUM_RUNS),
        .RUN_DEPTH (RUN_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_value   (item.load_value),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // An accepted pop keeps the input side busy while the scan runs
    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.operation == OP_POP |=> item_stall)
        else $error("input not stalled after pop transfer");

    // A new result only comes out of a scan, never straight from idle
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result raised without a preceding scan");

    // An empty pop reports zero value and run zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.all_empty |->
            result.merged_value == '0 && result.source_run == '0)
        else $error("empty result carries nonzero payload");

endmodule : kway_sorted_run_merge
`default_nettype wire
